/* hw/rtl/sss_pkg.sv */
// Shared widths and defaults for the sample set statistics block.
`default_nettype none

package sss_pkg;

    localparam int SAMPLE_W        = 24;
    localparam int CNT_W           = 5;
    localparam int SUM_W           = 29;
    localparam int SQ_W            = 51;
    localparam int SQR_W           = 48;
    localparam int MEAN_W          = 32;
    localparam int VAR_W           = 55;
    localparam int FRAC_W          = 8;
    localparam int DIV_W           = 63;
    localparam int DVS_W           = 9;
    localparam int MAX_SAMPLES_DEF = 16;

endpackage

`default_nettype wire

/* hw/rtl/sample_set_statistics_top.sv */
// Top level of the sample set statistics block: accumulation, sequencer and result register.
//
// Samples enter on the s_ channel, one transfer per sample, with s_last on the
// final sample of a set. Each sample is taken in ST_IDLE, which registers
// its square, and then in ST_SQ, which adds it to the sum of squares.
// After the final sample the sequencer forms n*sumsq and sum*sum, then runs
// one shared shift-subtract divider twice, one quotient bit per cycle over
// 63 bits: once for the mean and once for the variance. From each accepted
// sample until the block is back in ST_IDLE, s_ready stays low. A set that
// ran past MAX_SAMPLES skips the products and divisions and goes from ST_SQ
// straight to ST_DONE.
// The result is held in an output register on the m_ channel. While that
// result waits for m_ready, samples of the next set are still accepted;
// only the completion of the next set waits for the register to free up.
// Reset is synchronous and active low; it clears all accumulators and drops
// m_valid.
`default_nettype none

module sample_set_statistics_top
    import sss_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_sample,
    input  wire logic                       s_last,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_max_value,
    output logic signed [SAMPLE_W-1:0]      m_min_value,
    output logic signed [MEAN_W-1:0]        m_mean_fixed,
    output logic [VAR_W-1:0]                m_variance_fixed,
    output logic [CNT_W-1:0]                m_sample_count,
    output logic                            m_too_many
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_PROD = 3'd2;
    localparam logic [2:0] ST_DIFF = 3'd3;
    localparam logic [2:0] ST_DIVM = 3'd4;
    localparam logic [2:0] ST_DIVV = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    logic [2:0] state_reg, state_next;

    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [SQ_W-1:0]            sumsq_reg, sumsq_next;
    logic signed [SAMPLE_W-1:0] largest_reg, largest_next;
    logic signed [SAMPLE_W-1:0] smallest_reg, smallest_next;
    logic                       overflowed_reg, overflowed_next;
    logic                       last_reg, last_next;
    logic                       add_reg, add_next;
    logic [SQR_W-1:0]           square_reg, square_next;

    logic [VAR_W-1:0]  nsq_reg, nsq_next;
    logic [VAR_W-1:0]  ssq_reg, ssq_next;
    logic [SUM_W-1:0]  mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [VAR_W-1:0]  diff_reg, diff_next;
    logic [MEAN_W-1:0] mean_reg, mean_next;
    logic [VAR_W-1:0]  var_reg, var_next;

    logic                       m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0] m_max_reg, m_max_next;
    logic signed [SAMPLE_W-1:0] m_min_reg, m_min_next;
    logic [MEAN_W-1:0]          m_mean_reg, m_mean_next;
    logic [VAR_W-1:0]           m_var_reg, m_var_next;
    logic [CNT_W-1:0]           m_cnt_reg, m_cnt_next;
    logic                       m_tm_reg, m_tm_next;

    logic signed [2*SAMPLE_W-1:0] x_square;
    logic [VAR_W+CNT_W-1:0]       n_times_sq;
    logic signed [2*SUM_W-1:0]    sum_square;
    logic [2*CNT_W-1:0]           n_square;
    logic [DIV_W-1:0]             mean_dividend;
    logic [DIV_W-1:0]             div_dividend;
    logic [DVS_W-1:0]             div_divisor;
    logic                         div_start;
    logic                         div_done;
    logic [DIV_W-1:0]             div_quotient;
    logic                         in_xfer;
    logic                         out_free;

    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign x_square   = s_sample * s_sample;
    assign n_times_sq = {{(VAR_W){1'b0}}, count_reg} * {{(CNT_W+VAR_W-SQ_W){1'b0}}, sumsq_reg};
    assign sum_square = sum_reg * sum_reg;
    assign n_square   = count_reg * count_reg;

    assign mean_dividend = {{(DIV_W-SUM_W-FRAC_W){1'b0}}, mag_reg, {FRAC_W{1'b0}}}
                         + (neg_reg ? DIV_W'(count_reg - 1'b1) : '0);

    always_comb begin
        div_start    = 1'b0;
        div_dividend = mean_dividend;
        div_divisor  = DVS_W'(count_reg);
        if (state_reg == ST_DIFF) begin
            div_start = 1'b1;
        end else if (state_reg == ST_DIVM && div_done) begin
            div_start    = 1'b1;
            div_dividend = {diff_reg, {FRAC_W{1'b0}}};
            div_divisor  = n_square[DVS_W-1:0];
        end
    end

    sss_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        sumsq_next      = sumsq_reg;
        largest_next    = largest_reg;
        smallest_next   = smallest_reg;
        overflowed_next = overflowed_reg;
        last_next       = last_reg;
        add_next        = add_reg;
        square_next     = square_reg;
        nsq_next        = nsq_reg;
        ssq_next        = ssq_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        diff_next       = diff_reg;
        mean_next       = mean_reg;
        var_next        = var_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_max_next      = m_max_reg;
        m_min_next      = m_min_reg;
        m_mean_next     = m_mean_reg;
        m_var_next      = m_var_reg;
        m_cnt_next      = m_cnt_reg;
        m_tm_next       = m_tm_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    last_next   = s_last;
                    square_next = SQR_W'(x_square);
                    if (count_reg >= MAX_CNT) begin
                        overflowed_next = 1'b1;
                        add_next        = 1'b0;
                    end else begin
                        add_next   = 1'b1;
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + SUM_W'(s_sample);
                        if (count_reg == '0) begin
                            largest_next  = s_sample;
                            smallest_next = s_sample;
                        end else begin
                            if (s_sample > largest_reg) begin
                                largest_next = s_sample;
                            end
                            if (s_sample < smallest_reg) begin
                                smallest_next = s_sample;
                            end
                        end
                    end
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                if (add_reg) begin
                    sumsq_next = sumsq_reg + SQ_W'(square_reg);
                end
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (overflowed_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                nsq_next   = n_times_sq[VAR_W-1:0];
                ssq_next   = VAR_W'(sum_square);
                neg_next   = sum_reg[SUM_W-1];
                mag_next   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                diff_next  = nsq_reg - ssq_reg;
                state_next = ST_DIVM;
            end
            ST_DIVM: begin
                if (div_done) begin
                    mean_next  = neg_reg ? MEAN_W'(-div_quotient[MEAN_W-1:0])
                                         : div_quotient[MEAN_W-1:0];
                    state_next = ST_DIVV;
                end
            end
            ST_DIVV: begin
                if (div_done) begin
                    var_next   = div_quotient[VAR_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (overflowed_reg) begin
                        m_max_next  = '0;
                        m_min_next  = '0;
                        m_mean_next = '0;
                        m_var_next  = '0;
                        m_cnt_next  = MAX_CNT;
                        m_tm_next   = 1'b1;
                    end else begin
                        m_max_next  = largest_reg;
                        m_min_next  = smallest_reg;
                        m_mean_next = mean_reg;
                        m_var_next  = var_reg;
                        m_cnt_next  = count_reg;
                        m_tm_next   = 1'b0;
                    end
                    count_next      = '0;
                    sum_next        = '0;
                    sumsq_next      = '0;
                    largest_next    = '0;
                    smallest_next   = '0;
                    overflowed_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            sum_reg        <= '0;
            sumsq_reg      <= '0;
            largest_reg    <= '0;
            smallest_reg   <= '0;
            overflowed_reg <= 1'b0;
            last_reg       <= 1'b0;
            add_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            sumsq_reg      <= sumsq_next;
            largest_reg    <= largest_next;
            smallest_reg   <= smallest_next;
            overflowed_reg <= overflowed_next;
            last_reg       <= last_next;
            add_reg        <= add_next;
            m_valid_reg    <= m_valid_next;
        end
        square_reg <= square_next;
        nsq_reg    <= nsq_next;
        ssq_reg    <= ssq_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        diff_reg   <= diff_next;
        mean_reg   <= mean_next;
        var_reg    <= var_next;
        m_max_reg  <= m_max_next;
        m_min_reg  <= m_min_next;
        m_mean_reg <= m_mean_next;
        m_var_reg  <= m_var_next;
        m_cnt_reg  <= m_cnt_next;
        m_tm_reg   <= m_tm_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_max_value      = m_max_reg;
    assign m_min_value      = m_min_reg;
    assign m_mean_fixed     = m_mean_reg;
    assign m_variance_fixed = m_var_reg;
    assign m_sample_count   = m_cnt_reg;
    assign m_too_many       = m_tm_reg;

endmodule

`default_nettype wire

/* hw/rtl/sss_div.sv */
// Restoring shift-subtract divider that produces one quotient bit per cycle.
`default_nettype none

module sss_div
    import sss_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(DIV_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  work_reg, work_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] trial;
    logic           fits;

    assign shifted = {rem_reg, work_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        work_next = work_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            work_next = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
            work_next = {work_reg[DIV_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg  <= rem_next;
        work_reg <= work_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

`default_nettype wire

/* hw/rtl/sss_chk.sv */
// Port-level checker for the sample set statistics block, bound to the top level.
`default_nettype none

module sss_chk
    import sss_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire logic signed [SAMPLE_W-1:0] s_sample,
    input wire logic                       s_last,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic signed [SAMPLE_W-1:0] m_max_value,
    input wire logic signed [SAMPLE_W-1:0] m_min_value,
    input wire logic signed [MEAN_W-1:0]   m_mean_fixed,
    input wire logic [VAR_W-1:0]           m_variance_fixed,
    input wire logic [CNT_W-1:0]           m_sample_count,
    input wire logic                       m_too_many
);

    logic signed [MEAN_W-1:0] min_scaled;
    logic signed [MEAN_W-1:0] max_scaled;

    assign min_scaled = {m_min_value, {FRAC_W{1'b0}}};
    assign max_scaled = {m_max_value, {FRAC_W{1'b0}}};

    // After every sample transfer the block leaves ST_IDLE and s_ready drops.
    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready stayed high after a sample transfer");

    // A stalled result stays valid and keeps its mean, variance and count.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mean_fixed)
            && $stable(m_variance_fixed) && $stable(m_sample_count))
        else $error("result changed while stalled");

    // An overlong set reports zero values at the saturated count.
    a_overflow_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_too_many |-> m_max_value == '0 && m_min_value == '0
            && m_mean_fixed == '0 && m_variance_fixed == '0
            && m_sample_count == CNT_W'(MAX_SAMPLES))
        else $error("overflow result carries nonzero values");

    // A valid set has its mean between its extremes and a count in range.
    a_mean_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_too_many |-> m_min_value <= m_max_value
            && min_scaled <= m_mean_fixed && m_mean_fixed <= max_scaled
            && m_sample_count != '0 && m_sample_count <= CNT_W'(MAX_SAMPLES))
        else $error("mean outside the range of the set");

endmodule

bind sample_set_statistics_top sss_chk #(.MAX_SAMPLES(MAX_SAMPLES)) u_sss_chk (.*);

`default_nettype wire

/* test/sample_set_statistics_top_test.sv */
// Self-checking testbench for the sample set statistics block.
module sample_set_statistics_top_test;
    import sss_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } sample_item_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] max_value;
        logic signed [SAMPLE_W-1:0] min_value;
        logic signed [MEAN_W-1:0]   mean_fixed;
        logic [VAR_W-1:0]           variance_fixed;
        logic [CNT_W-1:0]           sample_count;
        logic                       too_many;
    } set_stats_t;

    typedef enum int {
        VALUES_ANY,
        VALUES_EXTREME,
        VALUES_NEAR_ZERO,
        VALUES_ALL_MAX,
        VALUES_ALL_MIN
    } value_style_t;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE
    } ready_mode_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample = '0;
    logic                       s_last = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_max_value;
    logic signed [SAMPLE_W-1:0] m_min_value;
    logic signed [MEAN_W-1:0]   m_mean_fixed;
    logic [VAR_W-1:0]           m_variance_fixed;
    logic [CNT_W-1:0]           m_sample_count;
    logic                       m_too_many;

    sample_item_t pending_samples[$];
    set_stats_t   stats_expected[$];

    int                acc_count = 0;
    longint            acc_sum = 0;
    longint unsigned   acc_square_sum = 0;
    longint            acc_largest = 0;
    longint            acc_smallest = 0;
    logic              acc_overflow = 1'b0;

    int          samples_sent = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          phase_left = 0;
    ready_mode_t ready_mode = READY_ALWAYS;
    logic        hold_off = 1'b0;

    sample_set_statistics_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_max_value      (m_max_value),
        .m_min_value      (m_min_value),
        .m_mean_fixed     (m_mean_fixed),
        .m_variance_fixed (m_variance_fixed),
        .m_sample_count   (m_sample_count),
        .m_too_many       (m_too_many)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] value,
                                     input logic fin);
        longint          x;
        longint          numer;
        longint          quot;
        longint unsigned n_u;
        longint unsigned sum_sq;
        longint unsigned diff;
        longint unsigned var_full;
        set_stats_t      res;
        x = value;
        if (acc_count >= MAX_SAMPLES_DEF) begin
            acc_overflow = 1'b1;
        end else begin
            if (acc_count == 0) begin
                acc_largest = x;
                acc_smallest = x;
            end else begin
                if (x > acc_largest) acc_largest = x;
                if (x < acc_smallest) acc_smallest = x;
            end
            acc_sum += x;
            acc_square_sum += longint'(x * x);
            acc_count++;
        end
        if (fin) begin
            if (acc_overflow) begin
                res.max_value = '0;
                res.min_value = '0;
                res.mean_fixed = '0;
                res.variance_fixed = '0;
                res.sample_count = CNT_W'(MAX_SAMPLES_DEF);
                res.too_many = 1'b1;
            end else begin
                numer = acc_sum * 256;
                quot = numer / acc_count;
                if ((numer % acc_count) != 0 && numer < 0) quot--;
                n_u = acc_count;
                sum_sq = acc_sum * acc_sum;
                diff = n_u * acc_square_sum - sum_sq;
                var_full = (diff * 256) / (n_u * n_u);
                res.max_value = acc_largest[SAMPLE_W-1:0];
                res.min_value = acc_smallest[SAMPLE_W-1:0];
                res.mean_fixed = quot[MEAN_W-1:0];
                res.variance_fixed = var_full[VAR_W-1:0];
                res.sample_count = CNT_W'(acc_count);
                res.too_many = 1'b0;
            end
            stats_expected.push_back(res);
            acc_count = 0;
            acc_sum = 0;
            acc_square_sum = 0;
            acc_largest = 0;
            acc_smallest = 0;
            acc_overflow = 1'b0;
        end
    endtask

    task automatic queue_sample(input logic signed [SAMPLE_W-1:0] value, input logic fin);
        sample_item_t item;
        item.sample = value;
        item.last = fin;
        pending_samples.push_back(item);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input value_style_t style);
        logic [31:0] r;
        r = $urandom;
        case (style)
            VALUES_EXTREME:   pick_sample = r[0] ? SAMPLE_MAX : SAMPLE_MIN;
            VALUES_NEAR_ZERO: pick_sample = SAMPLE_W'($signed(r[5:0]));
            VALUES_ALL_MAX:   pick_sample = SAMPLE_MAX;
            VALUES_ALL_MIN:   pick_sample = SAMPLE_MIN;
            default:          pick_sample = r[SAMPLE_W-1:0];
        endcase
    endfunction

    task automatic queue_set(input int len, input value_style_t style);
        for (int i = 0; i < len; i++) begin
            queue_sample(pick_sample(style), i == len - 1);
        end
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            if (mismatch_count < 10) begin
                $display("Mismatch in %s: expected %h, actual %h", field, want, got);
            end
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : sample_driver
        logic offer;
        offer = 1'b0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                accumulate_sample(pending_samples[0].sample, pending_samples[0].last);
                void'(pending_samples.pop_front());
                samples_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_samples.size() != 0) begin
                    offer = 1'b1;
                    s_sample <= pending_samples[0].sample;
                    s_last <= pending_samples[0].last;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                s_valid <= offer;
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        logic go;
        set_stats_t want;
        if (aresetn && m_valid && m_ready) begin
            if (stats_expected.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("Unexpected result transfer: max %h min %h mean %h var %h",
                             m_max_value, m_min_value, m_mean_fixed, m_variance_fixed);
                end
                mismatch_count++;
            end else begin
                want = stats_expected.pop_front();
                compare_field("max_value", want.max_value, m_max_value);
                compare_field("min_value", want.min_value, m_min_value);
                compare_field("mean_fixed", want.mean_fixed, m_mean_fixed);
                compare_field("variance_fixed", want.variance_fixed, m_variance_fixed);
                compare_field("sample_count", want.sample_count, m_sample_count);
                compare_field("too_many", want.too_many, m_too_many);
            end
        end
        if (phase_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            phase_left = $urandom_range(16, 96);
        end else begin
            phase_left--;
        end
        case (ready_mode)
            READY_ALWAYS: go = 1'b1;
            READY_COIN:   go = 1'($urandom_range(0, 1));
            default:      go = ($urandom_range(0, 3) == 0);
        endcase
        m_ready <= go && !hold_off && aresetn;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        while (samples_sent < 200) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        int r;
        value_style_t style;
        queue_sample(SAMPLE_MAX, 1'b1);
        queue_sample(SAMPLE_MIN, 1'b1);
        queue_sample(SAMPLE_MIN, 1'b0);
        queue_sample(SAMPLE_MAX, 1'b1);
        queue_sample(-24'sd1, 1'b0);
        queue_sample(24'sd0, 1'b0);
        queue_sample(24'sd0, 1'b1);
        queue_set(MAX_SAMPLES_DEF + 1, VALUES_ANY);

        while (pending_samples.size() < 620) begin
            r = $urandom_range(0, 9);
            style = value_style_t'($urandom_range(0, 4));
            if (r <= 5) queue_set($urandom_range(1, MAX_SAMPLES_DEF), style);
            else if (r <= 7) queue_set(MAX_SAMPLES_DEF, style);
            else if (r == 8) queue_set(1, style);
            else queue_set($urandom_range(MAX_SAMPLES_DEF + 1, MAX_SAMPLES_DEF + 4), style);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_samples.size() != 0 || s_valid) @(posedge aclk);
        while (stats_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && stats_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
